FILE: sv/unix_seconds_to_utc_date_unit_assert.svh
// Assertion macros for the RTL of the date converter.
// Each expands to a labeled concurrent assertion in simulation and to
// nothing in synthesis.
`ifndef UNIX_SECONDS_TO_UTC_DATE_UNIT_ASSERT_SVH
`define UNIX_SECONDS_TO_UTC_DATE_UNIT_ASSERT_SVH

`ifndef SYNTHESIS

// Same-cycle implication
`define USDU_ASSERT_IMP(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication
`define USDU_ASSERT_NXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`else

`define USDU_ASSERT_IMP(label, clk, rst, ante, cons, msg)
`define USDU_ASSERT_NXT(label, clk, rst, ante, cons, msg)

`endif

`endif

FILE: sv/usdu_pkg.sv
package usdu_pkg;

   // Field widths
   localparam int SecsW    = 32;
   localparam int YearW    = 12;
   localparam int MonthW   = 4;
   localparam int DayW     = 5;
   localparam int HourW    = 5;
   localparam int MinuteW  = 6;
   localparam int SecondW  = 6;
   localparam int RspDataW = 40;

   // Divider sizing
   localparam int DivisorW = 17;
   localparam int StepW    = 6;
   localparam int DaysW    = 16;

   // Time constants
   localparam logic [DivisorW-1:0] SecsPerDay    = 17'd86400;
   localparam logic [DivisorW-1:0] SecsPerHour   = 17'd3600;
   localparam logic [DivisorW-1:0] SecsPerMinute = 17'd60;

   // Bit counts per division: full word, second of day, second of hour
   localparam logic [StepW-1:0] DaySteps  = 6'd32;
   localparam logic [StepW-1:0] HourSteps = 6'd17;
   localparam logic [StepW-1:0] MinSteps  = 6'd12;

   // Calendar constants
   localparam logic [YearW-1:0] EpochYear  = 12'd1970;
   localparam logic [YearW-1:0] YearLimit  = 12'd2200;
   localparam logic [8:0]       LeapLen    = 9'd366;
   localparam logic [8:0]       CommonLen  = 9'd365;
   localparam logic [MonthW-1:0] MonthsPerYear = 4'd12;

   // Epoch year residues mod 4, 100 and 400
   localparam logic [1:0] EpochMod4   = 2'd2;
   localparam logic [6:0] EpochMod100 = 7'd70;
   localparam logic [8:0] EpochMod400 = 9'd370;

   // Month index, January is zero
   localparam logic [MonthW-1:0] MonJan = 4'd0;
   localparam logic [MonthW-1:0] MonFeb = 4'd1;
   localparam logic [MonthW-1:0] MonMar = 4'd2;
   localparam logic [MonthW-1:0] MonApr = 4'd3;
   localparam logic [MonthW-1:0] MonMay = 4'd4;
   localparam logic [MonthW-1:0] MonJun = 4'd5;
   localparam logic [MonthW-1:0] MonJul = 4'd6;
   localparam logic [MonthW-1:0] MonAug = 4'd7;
   localparam logic [MonthW-1:0] MonSep = 4'd8;
   localparam logic [MonthW-1:0] MonOct = 4'd9;
   localparam logic [MonthW-1:0] MonNov = 4'd10;
   localparam logic [MonthW-1:0] MonDec = 4'd11;

   // Command to the serial divider
   typedef struct packed {
      logic                start;
      logic [StepW-1:0]    steps;
      logic [DivisorW-1:0] divisor;
   } div_cmd_type;

   // Days in a month, February lengthened in a leap year
   function automatic logic [DayW-1:0] month_length(input logic [MonthW-1:0] mon,
                                                    input logic leap);
      logic [DayW-1:0] len;
      case (mon)
         MonJan, MonMar, MonMay, MonJul, MonAug, MonOct, MonDec: len = 5'd31;
         MonApr, MonJun, MonSep, MonNov:                         len = 5'd30;
         MonFeb:  len = leap ? 5'd29 : 5'd28;
         default: len = 5'd31;
      endcase
      return len;
   endfunction

endpackage

FILE: sv/unix_seconds_to_utc_date_unit.sv
// Channel   Dir  Handshake              Payload
// req_      in   req_tvalid/req_tready  unix_seconds
// rsp_      out  rsp_tvalid/rsp_tready  year, month, day_of_month, hour, minute, second
//
// One item at a time. Three bit-serial divisions (32, 17 and 12 steps) share one
// divider, then the walk drops one year per cycle and then one month per cycle.
// The next item is accepted once the result loads into the output register.
// Reset is synchronous and clears the sequencer and the output valid.
// A result waiting on rsp_tready holds in the output register and stalls the finished walk.

`include "unix_seconds_to_utc_date_unit_assert.svh"

module unix_seconds_to_utc_date_unit
   import usdu_pkg::*;
(
   input  logic                clock,
   input  logic                reset,
   input  logic                req_tvalid,
   output logic                req_tready,
   input  logic [SecsW-1:0]    req_tdata,   // [31:0] unix_seconds
   output logic                rsp_tvalid,
   input  logic                rsp_tready,
   output logic [RspDataW-1:0] rsp_tdata    // [11:0] year, [15:12] month,
                                            // [20:16] day_of_month, [25:21] hour,
                                            // [31:26] minute, [37:32] second_of_minute,
                                            // [39:38] zero
);

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_DAYS,
      ST_HOURS,
      ST_MINS,
      ST_YEARS,
      ST_MONTHS,
      ST_DONE
   } state_type;

   state_type            state_ff, state_in;
   logic [DaysW-1:0]     days_ff, days_in;
   logic [HourW-1:0]     hour_ff, hour_in;
   logic [MinuteW-1:0]   minute_ff, minute_in;
   logic [SecondW-1:0]   second_ff, second_in;
   logic [YearW-1:0]     year_ff, year_in;
   logic [1:0]           m4_ff, m4_in;
   logic [6:0]           m100_ff, m100_in;
   logic [8:0]           m400_ff, m400_in;
   logic [MonthW-1:0]    mon_ff, mon_in;
   logic                 rsp_valid_ff, rsp_valid_in;
   logic [RspDataW-1:0]  rsp_data_ff, rsp_data_in;

   div_cmd_type          div_cmd;
   logic [SecsW-1:0]     div_dividend;
   logic                 div_done;
   logic [SecsW-1:0]     div_quot;
   logic [DivisorW-1:0]  div_rem;

   logic                 leap;
   logic [8:0]           ylen;
   logic [DayW-1:0]      mlen;
   logic                 out_free;
   logic                 req_take;

   usdu_serial_div u_div (
      .clock     (clock),
      .reset     (reset),
      .cmd       (div_cmd),
      .dividend  (div_dividend),
      .done      (div_done),
      .quotient  (div_quot),
      .remainder (div_rem)
   );

   // Leap rule from the running residues of the year
   always_comb begin
      leap = ((m4_ff == 2'd0) && (m100_ff != 7'd0)) || (m400_ff == 9'd0);
      ylen = leap ? LeapLen : CommonLen;
      mlen = month_length(mon_ff, leap);
   end

   assign req_tready = (state_ff == ST_IDLE);
   assign req_take   = req_tvalid && req_tready;
   assign out_free   = !rsp_valid_ff || rsp_tready;

   always_comb begin
      state_in     = state_ff;
      days_in      = days_ff;
      hour_in      = hour_ff;
      minute_in    = minute_ff;
      second_in    = second_ff;
      year_in      = year_ff;
      m4_in        = m4_ff;
      m100_in      = m100_ff;
      m400_in      = m400_ff;
      mon_in       = mon_ff;
      rsp_data_in  = rsp_data_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      div_cmd      = '{start: 1'b0, steps: DaySteps, divisor: SecsPerDay};
      div_dividend = req_tdata;

      case (state_ff)
         ST_IDLE: begin
            // take an item and split off whole days
            if (req_take) begin
               div_cmd.start = 1'b1;
               state_in      = ST_DAYS;
            end
         end
         ST_DAYS: begin
            // hold the day count, divide the second of day by an hour
            div_cmd      = '{start: div_done, steps: HourSteps, divisor: SecsPerHour};
            div_dividend = {div_rem, {(SecsW-DivisorW){1'b0}}};
            if (div_done) begin
               days_in  = div_quot[DaysW-1:0];
               state_in = ST_HOURS;
            end
         end
         ST_HOURS: begin
            // hold the hour, divide the second of hour by a minute
            div_cmd      = '{start: div_done, steps: MinSteps, divisor: SecsPerMinute};
            div_dividend = {div_rem[11:0], {(SecsW-12){1'b0}}};
            if (div_done) begin
               hour_in  = div_quot[HourW-1:0];
               state_in = ST_MINS;
            end
         end
         ST_MINS: begin
            // hold minute and second, start the year walk at the epoch
            if (div_done) begin
               minute_in = div_quot[MinuteW-1:0];
               second_in = div_rem[SecondW-1:0];
               year_in   = EpochYear;
               m4_in     = EpochMod4;
               m100_in   = EpochMod100;
               m400_in   = EpochMod400;
               state_in  = ST_YEARS;
            end
         end
         ST_YEARS: begin
            // drop one whole year per cycle
            if ((year_ff < YearLimit) && (days_ff >= {{(DaysW-9){1'b0}}, ylen})) begin
               days_in = days_ff - {{(DaysW-9){1'b0}}, ylen};
               year_in = year_ff + 1'b1;
               m4_in   = m4_ff + 1'b1;
               m100_in = (m100_ff == 7'd99) ? 7'd0 : m100_ff + 1'b1;
               m400_in = (m400_ff == 9'd399) ? 9'd0 : m400_ff + 1'b1;
            end else begin
               mon_in   = MonJan;
               state_in = ST_MONTHS;
            end
         end
         ST_MONTHS: begin
            // drop one whole month per cycle
            if ((mon_ff < MonthsPerYear) && (days_ff >= {{(DaysW-DayW){1'b0}}, mlen})) begin
               days_in = days_ff - {{(DaysW-DayW){1'b0}}, mlen};
               mon_in  = mon_ff + 1'b1;
            end else begin
               state_in = ST_DONE;
            end
         end
         ST_DONE: begin
            // load the output register once it is free
            if (out_free) begin
               rsp_data_in  = {2'b00, second_ff, minute_ff, hour_ff,
                               days_ff[DayW-1:0] + 1'b1, mon_ff + 1'b1, year_ff};
               rsp_valid_in = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      days_ff     <= days_in;
      hour_ff     <= hour_in;
      minute_ff   <= minute_in;
      second_ff   <= second_in;
      year_ff     <= year_in;
      m4_ff       <= m4_in;
      m100_ff     <= m100_in;
      m400_ff     <= m400_in;
      mon_ff      <= mon_in;
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

   // Year residues must agree with each other during the walk
   `USDU_ASSERT_IMP(a_residues_agree, clock, reset,
      (state_ff == ST_YEARS) || (state_ff == ST_MONTHS),
      (m4_ff == m100_ff[1:0]) && (m4_ff == m400_ff[1:0]),
      "year residues out of step")

   // Year stays within the range a 32-bit count can reach
   `USDU_ASSERT_IMP(a_year_range, clock, reset,
      (state_ff == ST_YEARS) || (state_ff == ST_MONTHS),
      (year_ff >= EpochYear) && (year_ff <= 12'd2106),
      "year walk out of range")

   // Month walk never passes December and leaves a day within the month
   `USDU_ASSERT_IMP(a_month_bound, clock, reset,
      (state_ff == ST_DONE),
      (mon_ff < MonthsPerYear) && (days_ff < {{(DaysW-DayW){1'b0}}, mlen}),
      "month walk overran")

   // A finished walk with a free output shows a result next cycle
   `USDU_ASSERT_NXT(a_result_shown, clock, reset,
      (state_ff == ST_DONE) && out_free,
      rsp_tvalid && (state_ff == ST_IDLE),
      "finished item not delivered")

endmodule

FILE: sv/usdu_serial_div.sv
module usdu_serial_div
   import usdu_pkg::*;
(
   input  logic                clock,
   input  logic                reset,
   input  div_cmd_type         cmd,
   input  logic [SecsW-1:0]    dividend,   // left-aligned, consumed from the top bit
   output logic                done,
   output logic [SecsW-1:0]    quotient,   // quotient in the low 'steps' bits
   output logic [DivisorW-1:0] remainder
);

   logic                busy_ff, busy_in;
   logic                done_ff, done_in;
   logic [StepW-1:0]    count_ff, count_in;
   logic [SecsW-1:0]    shreg_ff, shreg_in;
   logic [DivisorW-1:0] rem_ff, rem_in;
   logic [DivisorW-1:0] divisor_ff, divisor_in;

   logic [DivisorW:0]   partial;
   logic [DivisorW:0]   diff;
   logic                qbit;

   // One restoring step: bring down the next bit, subtract if it fits
   always_comb begin
      partial = {rem_ff, shreg_ff[SecsW-1]};
      diff    = partial - {1'b0, divisor_ff};
      qbit    = (partial >= {1'b0, divisor_ff});
   end

   always_comb begin
      busy_in    = busy_ff;
      done_in    = 1'b0;
      count_in   = count_ff;
      shreg_in   = shreg_ff;
      rem_in     = rem_ff;
      divisor_in = divisor_ff;
      if (cmd.start) begin
         // load a new division
         busy_in    = 1'b1;
         count_in   = cmd.steps;
         shreg_in   = dividend;
         rem_in     = '0;
         divisor_in = cmd.divisor;
      end else if (busy_ff) begin
         // advance one quotient bit
         shreg_in = {shreg_ff[SecsW-2:0], qbit};
         rem_in   = qbit ? diff[DivisorW-1:0] : partial[DivisorW-1:0];
         count_in = count_ff - 1'b1;
         if (count_ff == 6'd1) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
      count_ff   <= count_in;
      shreg_ff   <= shreg_in;
      rem_ff     <= rem_in;
      divisor_ff <= divisor_in;
   end

   assign done      = done_ff;
   assign quotient  = shreg_ff;
   assign remainder = rem_ff;

endmodule
